/* rtl/htbd_pkg.sv */
// Package with shared types and constants of the Huffman table decoder.
package htbd_pkg;

	localparam int TableEntriesDef = 256;
	localparam int MaxCodeBitsDef = 32;

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_DATA  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	localparam logic [2:0] ST_OK   = 3'd0;
	localparam logic [2:0] ST_DUP  = 3'd1;
	localparam logic [2:0] ST_FULL = 3'd2;
	localparam logic [2:0] ST_LONG = 3'd3;
	localparam logic [2:0] ST_HALT = 3'd4;
	localparam logic [2:0] ST_OVF  = 3'd5;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  symbol;
		logic [5:0]  code_len;
		logic [31:0] code_bits;
		logic [7:0]  data_byte;
		logic [3:0]  bit_count;
	} in_item_t;

	typedef struct packed {
		logic       is_symbol;
		logic [7:0] out_symbol;
		logic [2:0] status;
		logic       last;
	} out_item_t;

endpackage

/* rtl/htbd_ram.sv */
// Generic single-port-write, one-read synchronous RAM with registered read data.
module htbd_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/huffman_table_bit_decoder_core.sv */
// Top level of the Huffman decoder with an explicitly loaded code table.
// The block handles one item at a time. Codes live in one synchronous RAM of
// TABLE_ENTRIES entries that is scanned one entry per cycle. A load item scans
// the table for a duplicate, then reports and, if the entry is new and the table
// is not full, stores it, and goes back to idle before the next item is taken.
// A data item, for each bit, appends it, scans the table until the first match
// or the last entry, and then reports. Clear, halted, too-long load, zero-bit
// and unused-kind items are handled in the idle state. The result of a bit is
// held back until the next result or the end of the byte, so that the final one
// carries last. Results wait in an output register; while it is stalled the
// sequencer waits before it reports or takes a new item.
module huffman_table_bit_decoder_core #(
	parameter int TABLE_ENTRIES = htbd_pkg::TableEntriesDef,
	parameter int MAX_CODE_BITS = htbd_pkg::MaxCodeBitsDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  htbd_pkg::in_item_t in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output htbd_pkg::out_item_t out_data
);
	import htbd_pkg::*;

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int LW = $clog2(MAX_CODE_BITS + 1);
	localparam int EW = 8 + LW + MAX_CODE_BITS;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SCAN = 5'b00010,
		S_OUT  = 5'b00100,
		S_BIT  = 5'b01000,
		S_NEXT = 5'b10000
	} state_t;

	state_t state_q;
	logic [CW-1:0] count_q, idx_q;
	logic [MAX_CODE_BITS-1:0] acc_q, key_code_q;
	logic [LW-1:0] acc_len_q, key_len_q;
	logic halt_q, is_load_q, rd_pend_q;
	logic [7:0] byte_q, sym_q;
	logic [3:0] bits_left_q;
	logic out_valid_q, out_last_q, pend_valid_q;
	out_item_t out_q, pend_q;

	logic we;
	logic [AW-1:0] raddr;
	logic [EW-1:0] wdata, rdata;
	logic [7:0] r_sym;
	logic [LW-1:0] r_len;
	logic [MAX_CODE_BITS-1:0] r_code;
	logic hit, out_free, bit_res, out_set;

	htbd_ram #(.Width(EW), .Depth(TABLE_ENTRIES)) u_table (
		.clk(clk), .we(we), .waddr(count_q[AW-1:0]), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign {r_sym, r_len, r_code} = rdata;
	assign hit = rd_pend_q && (r_len == key_len_q) && (r_code == key_code_q);
	assign wdata = {sym_q, key_len_q, key_code_q};
	assign raddr = idx_q[AW-1:0];
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE) || !out_free;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// Incoming code masked to its length.
	logic [MAX_CODE_BITS-1:0] in_code;
	logic [LW-1:0] in_len;
	always_comb begin
		in_code = '0;
		for (int i = 0; i < MAX_CODE_BITS; i++) begin
			if (i < 32 && i < int'(in_data.code_len)) begin
				in_code[i] = in_data.code_bits[i];
			end
		end
		in_len = LW'(in_data.code_len);
	end

	logic too_long;
	assign too_long = 32'(in_data.code_len) > 32'(MAX_CODE_BITS);

	logic new_bit;
	logic [MAX_CODE_BITS-1:0] acc_next;
	assign new_bit = byte_q[7];
	assign acc_next = {acc_q[MAX_CODE_BITS-2:0], new_bit};

	// A bit gives a result on a match or when the accumulator is full.
	assign bit_res = out_last_q || (32'(acc_len_q) >= 32'(MAX_CODE_BITS));

	// Table write of a new entry, taken when the load is accepted as ok.
	assign we = (state_q == S_OUT) && out_free && is_load_q && !out_last_q &&
		(count_q != CW'(TABLE_ENTRIES));

	// The output register is loaded in these cycles.
	always_comb begin
		unique case (state_q)
			S_IDLE: out_set = in_valid && out_free && ((in_data.kind == KIND_CLEAR) ||
				(in_data.kind == KIND_LOAD && (halt_q || too_long)) ||
				(in_data.kind == KIND_DATA && halt_q));
			S_OUT: out_set = out_free && (is_load_q || (bit_res && pend_valid_q));
			S_NEXT: out_set = out_free && pend_valid_q;
			default: out_set = 1'b0;
		endcase
	end

	// Output valid: set on a new result, cleared once the transfer is done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_set) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Control sequencer: one table entry is compared per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q <= '0;
			acc_q <= '0;
			acc_len_q <= '0;
			key_code_q <= '0;
			key_len_q <= '0;
			halt_q <= 1'b0;
			is_load_q <= 1'b0;
			rd_pend_q <= 1'b0;
			byte_q <= '0;
			sym_q <= '0;
			bits_left_q <= '0;
			out_last_q <= 1'b0;
			pend_valid_q <= 1'b0;
			out_q <= '0;
			pend_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && out_free) begin
						priority if (in_data.kind == KIND_CLEAR) begin
							count_q <= '0;
							acc_q <= '0;
							acc_len_q <= '0;
							halt_q <= 1'b0;
							out_q <= '{is_symbol: 1'b0, out_symbol: 8'd0, status: ST_OK,
								last: 1'b1};
						end else if (in_data.kind == KIND_LOAD) begin
							if (halt_q || too_long) begin
								out_q <= '{is_symbol: 1'b0, out_symbol: 8'd0,
									status: halt_q ? ST_HALT : ST_LONG, last: 1'b1};
							end else begin
								is_load_q <= 1'b1;
								key_code_q <= in_code;
								key_len_q <= in_len;
								sym_q <= in_data.symbol;
								idx_q <= '0;
								rd_pend_q <= 1'b0;
								state_q <= S_SCAN;
							end
						end else if (in_data.kind == KIND_DATA) begin
							if (halt_q) begin
								out_q <= '{is_symbol: 1'b0, out_symbol: 8'd0, status: ST_HALT,
									last: 1'b1};
							end else if (in_data.bit_count != 4'd0) begin
								byte_q <= in_data.data_byte;
								bits_left_q <= (in_data.bit_count > 4'd8) ? 4'd8 :
									in_data.bit_count;
								is_load_q <= 1'b0;
								state_q <= S_BIT;
							end
						end else begin
							// The unused kind is dropped without a result.
						end
					end
				end
				S_BIT: begin
					// Append one bit, then scan the table for it.
					acc_q <= acc_next;
					acc_len_q <= acc_len_q + 1'b1;
					key_code_q <= acc_next;
					key_len_q <= acc_len_q + 1'b1;
					byte_q <= {byte_q[6:0], 1'b0};
					bits_left_q <= bits_left_q - 4'd1;
					idx_q <= '0;
					rd_pend_q <= 1'b0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (hit || idx_q == count_q) begin
						rd_pend_q <= 1'b0;
						state_q <= S_OUT;
					end else begin
						idx_q <= idx_q + 1'b1;
						rd_pend_q <= 1'b1;
					end
					if (hit && !is_load_q) begin
						sym_q <= r_sym;
					end
					out_last_q <= hit;
				end
				S_OUT: begin
					if (out_free) begin
						if (is_load_q) begin
							if (out_last_q) begin
								out_q <= '{is_symbol: 1'b0, out_symbol: 8'd0, status: ST_DUP,
									last: 1'b1};
								halt_q <= 1'b1;
							end else if (count_q == CW'(TABLE_ENTRIES)) begin
								out_q <= '{is_symbol: 1'b0, out_symbol: 8'd0, status: ST_FULL,
									last: 1'b1};
							end else begin
								out_q <= '{is_symbol: 1'b0, out_symbol: 8'd0, status: ST_OK,
									last: 1'b1};
								count_q <= count_q + 1'b1;
							end
							state_q <= S_IDLE;
						end else begin
							// A new result pushes out the held one, which is then not the last.
							if (bit_res) begin
								if (pend_valid_q) begin
									out_q <= pend_q;
								end
								pend_q <= '{is_symbol: out_last_q,
									out_symbol: out_last_q ? sym_q : 8'd0,
									status: out_last_q ? ST_OK : ST_OVF, last: 1'b0};
								pend_valid_q <= 1'b1;
								acc_q <= '0;
								acc_len_q <= '0;
							end
							state_q <= (bits_left_q == 4'd0) ? S_NEXT : S_BIT;
						end
					end
				end
				S_NEXT: begin
					// Byte ended: the held result, if any, is the last one.
					if (out_free) begin
						if (pend_valid_q) begin
							out_q <= '{is_symbol: pend_q.is_symbol, out_symbol: pend_q.out_symbol,
								status: pend_q.status, last: 1'b1};
						end
						pend_valid_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
